/* src/dlef_pkg.sv */
// Shared types and constants for the dilated Laplacian edge filter.
`default_nettype none

package dlef_pkg;

  localparam int PIX_W      = 8;
  localparam int PIX_MAX    = 255;
  // The centre tap weighs eight, which is a left shift by three.
  localparam int GAIN_SHIFT = 3;

  // Configuration port layout and register indexes.
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING     = 2'd2;

  // Raw register field widths and reset values.
  localparam int LINE_LENGTH_W   = 9;
  localparam int LINE_COUNT_W    = 10;
  localparam int SPACING_W       = 3;
  localparam int LINE_LENGTH_RST = 240;
  localparam int LINE_COUNT_RST  = 320;
  localparam int SPACING_RST     = 2;

  // Entries in the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel;
  } pix_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_res;
    logic             frame_last;
  } res_item_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             first;
    logic             emit;
    logic             last;
    logic             top_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
  } cmd_t;

endpackage

`default_nettype wire

/* src/dlef_ram.sv */
// Generic single-write, single-read RAM with registered read-first output.
`default_nettype none

module dlef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire              clk,
  input  wire              we,
  input  wire  [AW-1:0]    waddr,
  input  wire  [WIDTH-1:0] wdata,
  input  wire              re,
  input  wire  [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/dlef_fifo.sv */
// Short command queue between the classifying front and the filtering back.
`default_nettype none

module dlef_fifo
  import dlef_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        push,
  input  wire cmd_t  push_cmd,
  output logic       full,
  input  wire        pop,
  output cmd_t       pop_cmd,
  output logic       empty
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // The front must hold off while the queue is full.
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("dlef_fifo: item pushed into a full queue");

endmodule

`default_nettype wire

/* src/dlef_front.sv */
// Front part: configuration registers, frame position tracking and item classification.
`default_nettype none

module dlef_front
  import dlef_pkg::*;
#(
  parameter int MAX_LINE    = 256,
  parameter int MAX_LINES   = 512,
  parameter int MAX_SPACING = 4,
  localparam int SP_W   = $clog2(MAX_SPACING + 1),
  localparam int SPAN_W = $clog2(MAX_SPACING * MAX_LINE + 1)
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_we,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data,
  input  wire                    pix_valid,
  input  wire pix_item_t         pix,
  output logic                   pix_stall,
  input  wire                    q_full,
  output logic                   q_push,
  output cmd_t                   q_cmd,
  output logic [SP_W-1:0]        spacing,
  output logic [SPAN_W-1:0]      span
);

  localparam int LEN_W  = $clog2(MAX_LINE + 1);
  localparam int CNT_W  = $clog2(MAX_LINES + 1);
  localparam int COL_W  = $clog2(MAX_LINE);
  localparam int ROW_W  = $clog2(MAX_LINES);
  localparam int POS_W  =
    $clog2(MAX_LINE * MAX_LINES + MAX_SPACING * MAX_LINE + MAX_SPACING + 1);
  localparam int LL_RST = (LINE_LENGTH_RST > MAX_LINE) ? MAX_LINE : LINE_LENGTH_RST;
  localparam int LC_RST = (LINE_COUNT_RST > MAX_LINES) ? MAX_LINES : LINE_COUNT_RST;
  localparam int SP_RST = (SPACING_RST > MAX_SPACING) ? MAX_SPACING : SPACING_RST;

  function automatic int clamp_reg(input int v, input int hi);
    int r;
    r = v;
    if (v < 1) begin
      r = 1;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  logic [LEN_W-1:0] line_length;
  logic [CNT_W-1:0] line_count;
  logic [POS_W-1:0] in_pos;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_line;
  logic [POS_W-1:0] delay;
  logic             accept;
  logic             cfg_restart;
  logic             emit;
  logic             col_end;
  logic             row_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= LEN_W'(LL_RST);
      line_count  <= CNT_W'(LC_RST);
      spacing     <= SP_W'(SP_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_LENGTH: begin
          line_length <= LEN_W'(clamp_reg(int'(cfg_data[LINE_LENGTH_W-1:0]), MAX_LINE));
        end
        REG_LINE_COUNT: begin
          line_count <= CNT_W'(clamp_reg(int'(cfg_data[LINE_COUNT_W-1:0]), MAX_LINES));
        end
        REG_SPACING: begin
          spacing <= SP_W'(clamp_reg(int'(cfg_data[SPACING_W-1:0]), MAX_SPACING));
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_restart = cfg_we && (cfg_index == REG_LINE_LENGTH ||
                                  cfg_index == REG_LINE_COUNT ||
                                  cfg_index == REG_SPACING);

  // A result for stream position p is due once position p + span + spacing arrives.
  assign span  = SPAN_W'(SPAN_W'(spacing) * SPAN_W'(line_length));
  assign delay = POS_W'(span) + POS_W'(spacing);
  assign emit  = (in_pos >= delay);

  assign col_end = (int'(out_col) == int'(line_length) - 1);
  assign row_end = (int'(out_line) == int'(line_count) - 1);

  assign accept    = pix_valid && !q_full;
  assign pix_stall = q_full;
  assign q_push    = accept;

  always_comb begin
    q_cmd.value    = pix.mode ? '0 : pix.pixel;
    q_cmd.first    = (in_pos == '0);
    q_cmd.emit     = emit;
    q_cmd.last     = row_end && col_end;
    q_cmd.top_ok   = (int'(out_line) >= int'(spacing));
    q_cmd.bot_ok   = (int'(out_line) + int'(spacing) < int'(line_count));
    q_cmd.left_ok  = (int'(out_col) >= int'(spacing));
    q_cmd.right_ok = (int'(out_col) + int'(spacing) < int'(line_length));
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      in_pos   <= '0;
      out_col  <= '0;
      out_line <= '0;
    end else if (accept) begin
      if (emit && row_end && col_end) begin
        in_pos   <= '0;
        out_col  <= '0;
        out_line <= '0;
      end else begin
        in_pos <= in_pos + 1'b1;
        if (emit) begin
          if (col_end) begin
            out_col  <= '0;
            out_line <= out_line + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

  // Until the first result is due, the output position stays at the frame origin.
  assert property (@(posedge clk) disable iff (rst)
                   !emit |-> (out_col == '0 && out_line == '0))
    else $error("dlef_front: output position moved before the first result");

  // While results are due, the output line stays inside the frame.
  assert property (@(posedge clk) disable iff (rst)
                   emit |-> (int'(out_line) < int'(line_count)))
    else $error("dlef_front: output line ran past the frame");

endmodule

`default_nettype wire

/* src/dlef_back.sv */
// Back part: two line delays, the dilated 3x3 window and the clamped Laplacian.
`default_nettype none

module dlef_back
  import dlef_pkg::*;
#(
  parameter int MAX_LINE    = 256,
  parameter int MAX_SPACING = 4,
  localparam int SP_W   = $clog2(MAX_SPACING + 1),
  localparam int SPAN_W = $clog2(MAX_SPACING * MAX_LINE + 1)
) (
  input  wire                clk,
  input  wire                rst,
  input  wire  [SP_W-1:0]    spacing,
  input  wire  [SPAN_W-1:0]  span,
  input  wire                q_empty,
  input  wire cmd_t          q_cmd,
  output logic               q_pop,
  output logic               res_valid,
  input  wire                res_stall,
  output res_item_t          res
);

  localparam int DEPTH = MAX_SPACING * MAX_LINE;
  localparam int AW    = $clog2(DEPTH);
  localparam int WIN_N = 2 * MAX_SPACING + 1;
  localparam int IW    = $clog2(WIN_N);
  localparam int SUM_W = PIX_W + GAIN_SHIFT;

  logic             en;
  logic             s1_go;
  logic [AW-1:0]    ptr;
  logic [AW-1:0]    ptr0;
  logic [AW-1:0]    ptr_next;
  logic [PIX_W-1:0] mid_new;
  logic [PIX_W-1:0] top_new;

  logic             s1_valid;
  cmd_t             s1_cmd;
  logic [AW-1:0]    s1_ptr;
  logic             s2_valid;
  cmd_t             s2_cmd;
  logic [PIX_W-1:0] s2_mid;
  logic             s3_valid;
  cmd_t             s3_cmd;
  logic             s4_valid;
  logic [SUM_W-1:0] s4_center;
  logic [SUM_W-1:0] s4_neg;
  logic             s4_last;

  logic [PIX_W-1:0] win_top [WIN_N];
  logic [PIX_W-1:0] win_mid [WIN_N];
  logic [PIX_W-1:0] win_bot [WIN_N];

  logic [IW-1:0]    idx1;
  logic [IW-1:0]    idx2;
  logic [SUM_W-1:0] neg_sum;
  logic [SUM_W-1:0] diff;
  logic [PIX_W-1:0] clamped;

  // The whole pipeline moves together whenever the output register can take a result.
  assign en    = !res_valid || !res_stall;
  assign q_pop = en && !q_empty;
  assign s1_go = en && s1_valid;

  assign ptr0     = q_cmd.first ? '0 : ptr;
  assign ptr_next = (int'(ptr0) == int'(span) - 1) ? '0 : ptr0 + 1'b1;

  // First delay: the stream one dilated line back.
  dlef_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_mid_line (
    .clk   (clk),
    .we    (q_pop),
    .waddr (ptr0),
    .wdata (q_cmd.value),
    .re    (q_pop),
    .raddr (ptr0),
    .rdata (mid_new)
  );

  // Second delay: the stream two dilated lines back.
  dlef_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_top_line (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_ptr),
    .wdata (mid_new),
    .re    (s1_go),
    .raddr (s1_ptr),
    .rdata (top_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      if (q_pop) begin
        ptr <= ptr_next;
      end
      s1_valid  <= q_pop;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid && s3_cmd.emit;
      res_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd       <= q_cmd;
      s1_ptr       <= ptr0;
      s2_cmd       <= s1_cmd;
      s2_mid       <= mid_new;
      s3_cmd       <= s2_cmd;
      s4_center    <= {win_mid[idx1], GAIN_SHIFT'(0)};
      s4_neg       <= neg_sum;
      s4_last      <= s3_cmd.last;
      res.edge_res   <= clamped;
      res.frame_last <= s4_last;
    end
  end

  // Each row keeps the newest pixel at index zero and older ones behind it.
  always_ff @(posedge clk) begin
    if (en && s2_valid) begin
      win_bot[0] <= s2_cmd.value;
      win_mid[0] <= s2_mid;
      win_top[0] <= top_new;
      for (int i = 1; i < WIN_N; i++) begin
        win_bot[i] <= win_bot[i-1];
        win_mid[i] <= win_mid[i-1];
        win_top[i] <= win_top[i-1];
      end
    end
  end

  // Index zero is the right column, spacing the centre column, twice spacing the left.
  assign idx1 = IW'(spacing);
  assign idx2 = IW'(2 * int'(spacing));

  always_comb begin
    neg_sum = '0;
    if (s3_cmd.top_ok) begin
      neg_sum = neg_sum + SUM_W'(win_top[idx1]);
      if (s3_cmd.left_ok) begin
        neg_sum = neg_sum + SUM_W'(win_top[idx2]);
      end
      if (s3_cmd.right_ok) begin
        neg_sum = neg_sum + SUM_W'(win_top[0]);
      end
    end
    if (s3_cmd.left_ok) begin
      neg_sum = neg_sum + SUM_W'(win_mid[idx2]);
    end
    if (s3_cmd.right_ok) begin
      neg_sum = neg_sum + SUM_W'(win_mid[0]);
    end
    if (s3_cmd.bot_ok) begin
      neg_sum = neg_sum + SUM_W'(win_bot[idx1]);
      if (s3_cmd.left_ok) begin
        neg_sum = neg_sum + SUM_W'(win_bot[idx2]);
      end
      if (s3_cmd.right_ok) begin
        neg_sum = neg_sum + SUM_W'(win_bot[0]);
      end
    end
  end

  assign diff = s4_center - s4_neg;

  always_comb begin
    if (s4_neg >= s4_center) begin
      clamped = '0;
    end else if (int'(diff) > PIX_MAX) begin
      clamped = PIX_W'(PIX_MAX);
    end else begin
      clamped = diff[PIX_W-1:0];
    end
  end

  // A held result must freeze the delay lines and the window feed.
  assert property (@(posedge clk) disable iff (rst)
                   res_valid && res_stall |=> $stable(ptr) && $stable(s1_valid))
    else $error("dlef_back: pipeline advanced while the result was held");

endmodule

`default_nettype wire

/* src/dilated_laplacian_edge_filter.sv */
// Top level of the dilated Laplacian edge filter over a raster grey pixel stream.
// Throughput is one item per cycle while results are taken; the queue absorbs short stalls.
// A result passes the queue, stages s1 to s4 and the output register after the item that
// releases it is taken, spacing*line_length + spacing positions after the result's pixel.
// Synchronous reset sets line_length 240, line_count 320, spacing 2 and restarts the frame;
// the line delays are not cleared, since every stale entry falls on a masked tap.
`default_nettype none

module dilated_laplacian_edge_filter
  import dlef_pkg::*;
#(
  parameter int MAX_LINE    = 256,
  parameter int MAX_LINES   = 512,
  parameter int MAX_SPACING = 4
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_we,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data,
  input  wire                    pix_valid,
  output logic                   pix_stall,
  input  wire pix_item_t         pix,
  output logic                   res_valid,
  input  wire                    res_stall,
  output res_item_t              res
);

  localparam int SP_W   = $clog2(MAX_SPACING + 1);
  localparam int SPAN_W = $clog2(MAX_SPACING * MAX_LINE + 1);

  // The front counts stream positions, decides whether an item releases a result,
  // and computes which of the eight neighbor taps of that result lie inside the frame.
  // Every accepted item becomes one command, including flush items and items that
  // only fill the delay lines at the start of a frame.
  logic              q_full;
  logic              q_push;
  cmd_t              q_in;
  logic              q_pop;
  cmd_t              q_out;
  logic              q_empty;
  logic [SP_W-1:0]   spacing;
  logic [SPAN_W-1:0] span;

  dlef_front #(
    .MAX_LINE    (MAX_LINE),
    .MAX_LINES   (MAX_LINES),
    .MAX_SPACING (MAX_SPACING)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix       (pix),
    .pix_stall (pix_stall),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in),
    .spacing   (spacing),
    .span      (span)
  );

  // The queue lets the front keep taking items while a result waits at the output.
  dlef_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_out),
    .empty    (q_empty)
  );

  // The back runs each command through two line delays of spacing*line_length pixels,
  // shifts the three resulting rows into the window, sums the masked neighbors and
  // clamps eight times the centre minus that sum into the output register.
  dlef_back #(
    .MAX_LINE    (MAX_LINE),
    .MAX_SPACING (MAX_SPACING)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .spacing   (spacing),
    .span      (span),
    .q_empty   (q_empty),
    .q_cmd     (q_out),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire
